FILE: hw/rtl/wcf_pkg.sv
// shared types, constants and helpers of the 3x3 window convolution filter
package wcf_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int PixW      = 8;
  localparam int CfgW      = 11;
  localparam int ModeW     = 3;
  localparam int ApbAddrW  = 4;
  localparam int ApbDataW  = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegWidthIdx  = 2'd0;
  localparam logic [1:0] RegHeightIdx = 2'd1;
  localparam logic [1:0] RegModeIdx   = 2'd2;

  // box weight 0.11111 as exact ratio, with reciprocal estimate
  localparam int BoxNum     = 11111;
  localparam int BoxDen     = 100000;
  localparam int BoxShift   = 16;
  localparam int BoxRecip   = (BoxNum * (1 << BoxShift)) / BoxDen;
  localparam int BoxSumW    = 12;
  localparam int BoxRecipW  = 24;
  localparam int BoxProdW   = 25;
  // divide by three through reciprocal
  localparam int Div3Shift  = 17;
  localparam int Div3Recip  = ((1 << Div3Shift) / 3) + 1;
  localparam int Div3ProdW  = 28;
  localparam int ValW       = 14;

  typedef enum logic [ModeW-1:0] {
    ModeBox      = 3'd0,
    ModeGauss    = 3'd1,
    ModePrewittX = 3'd2,
    ModePrewittY = 3'd3,
    ModeSobelX   = 3'd4,
    ModeSobelY   = 3'd5,
    ModeLaplace  = 3'd6,
    ModeSharpen  = 3'd7
  } mode_e;

  typedef logic [8:0][PixW-1:0] win_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            interior;
    logic            last;
    mode_e           mode;
  } pix_meta_t;

  typedef struct packed {
    logic [ColW-1:0] wm1;
    logic [RowW-1:0] hm1;
    logic            restart;
    mode_e           mode;
  } frame_cfg_t;

  function automatic logic [ColW-1:0] width_m1(input logic [CfgW-1:0] v);
    if (int'(v) < 3) begin
      return ColW'(2);
    end else if (int'(v) > MaxWidth) begin
      return ColW'(MaxWidth - 1);
    end else begin
      return ColW'(int'(v) - 1);
    end
  endfunction

  function automatic logic [RowW-1:0] height_m1(input logic [CfgW-1:0] v);
    if (int'(v) < 3) begin
      return RowW'(2);
    end else if (int'(v) > MaxHeight) begin
      return RowW'(MaxHeight - 1);
    end else begin
      return RowW'(int'(v) - 1);
    end
  endfunction

  function automatic logic signed [ValW-1:0] abs_val(input logic signed [ValW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

FILE: hw/rtl/wcf_line_mem.sv
// two line memories holding the previous two rows, one read and one write each
module wcf_line_mem import wcf_pkg::*; (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [ColW-1:0] addr_i,
  input  logic [PixW-1:0] wr_px_i,
  input  logic            wr_above_en_i,
  input  logic [ColW-1:0] wr_above_addr_i,
  input  logic [PixW-1:0] wr_above_i,
  output logic [PixW-1:0] above_o,
  output logic [PixW-1:0] above2_o
);

  logic [PixW-1:0] line0_mem [MaxWidth];
  logic [PixW-1:0] line1_mem [MaxWidth];
  logic [PixW-1:0] above_q;
  logic [PixW-1:0] above2_q;

  // line0 is read and refreshed with the new pixel at the same address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      above_q          <= line0_mem[addr_i];
      above2_q         <= line1_mem[addr_i];
      line0_mem[addr_i] <= wr_px_i;
    end
    if (wr_above_en_i) begin
      line1_mem[wr_above_addr_i] <= wr_above_i;
    end
  end

  assign above_o  = above_q;
  assign above2_o = above2_q;

endmodule

FILE: hw/rtl/wcf_window.sv
// raster counters, line memory access and 3x3 window registers
module wcf_window import wcf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  frame_cfg_t      cfg_i,
  input  logic            in_valid_i,
  input  logic [PixW-1:0] pixel_i,
  output logic            in_stall_o,
  input  logic            win_ready_i,
  output logic            win_valid_o,
  output win_t            win_o,
  output pix_meta_t       meta_o
);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            s0_valid_q;
  pix_meta_t       s0_meta_q;
  logic [PixW-1:0] s0_px_q;
  logic            s1_valid_q;
  pix_meta_t       s1_meta_q;
  win_t            win_q;
  pix_meta_t       acc_meta;
  logic            en0;
  logic            en1;
  logic            accept;
  logic [PixW-1:0] above;
  logic [PixW-1:0] above2;

  // border items leave the window stage without a downstream handshake
  assign en1        = !s1_valid_q || !s1_meta_q.interior || win_ready_i;
  assign en0        = !s0_valid_q || en1;
  assign accept     = in_valid_i && en0;
  assign in_stall_o = !en0;

  always_comb begin
    acc_meta.col      = col_q;
    acc_meta.row      = row_q;
    acc_meta.interior = (col_q >= ColW'(2)) && (row_q >= RowW'(2));
    acc_meta.last     = (col_q == cfg_i.wm1) && (row_q == cfg_i.hm1);
    acc_meta.mode     = cfg_i.mode;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == cfg_i.wm1) begin
        col_d = '0;
        row_d = (row_q == cfg_i.hm1) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (en0) begin
        s0_valid_q <= accept;
      end
      if (en1) begin
        s1_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_meta_q <= acc_meta;
      s0_px_q   <= pixel_i;
    end
    if (en1 && s0_valid_q) begin
      s1_meta_q <= s0_meta_q;
    end
  end

  // window shifts left once per transaction leaving the memory read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (en1 && s0_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= above2;
      win_q[5] <= above;
      win_q[8] <= s0_px_q;
    end
  end

  wcf_line_mem u_line_mem (
    .clk_i           (clk_i),
    .rd_en_i         (accept),
    .addr_i          (col_q),
    .wr_px_i         (pixel_i),
    .wr_above_en_i   (s0_valid_q),
    .wr_above_addr_i (s0_meta_q.col),
    .wr_above_i      (above),
    .above_o         (above),
    .above2_o        (above2)
  );

  assign win_valid_o = s1_valid_q && s1_meta_q.interior;
  assign win_o       = win_q;
  assign meta_o      = s1_meta_q;

endmodule

FILE: hw/rtl/wcf_kernel.sv
// filter arithmetic pipeline and output register
module wcf_kernel import wcf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            win_valid_i,
  input  win_t            win_i,
  input  pix_meta_t       meta_i,
  output logic            win_ready_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PixW-1:0] filtered_o,
  output logic [ColW-1:0] centre_col_o,
  output logic [RowW-1:0] centre_row_o,
  output logic            frame_last_o
);

  logic en2, en3, en4, en_out;

  logic                       s2_valid_q;
  pix_meta_t                  s2_meta_q;
  logic signed [ValW-1:0]     s2_val_q, s2_val_d;

  logic                       s3_valid_q;
  pix_meta_t                  s3_meta_q;
  logic [PixW-1:0]            s3_res_q, s3_res_d;
  logic [BoxRecipW-1:0]       s3_quo_q, s3_quo_d;
  logic [BoxProdW-1:0]        s3_num_q, s3_num_d;

  logic                       s4_valid_q;
  pix_meta_t                  s4_meta_q;
  logic [PixW-1:0]            s4_res_q;
  logic [PixW-1:0]            s4_q0_q;
  logic [BoxProdW-1:0]        s4_num_q;
  logic [BoxProdW-1:0]        s4_mq_q;

  logic                       out_valid_q;
  logic [PixW-1:0]            filtered_q, filtered_d;
  logic [ColW-1:0]            ccol_q;
  logic [RowW-1:0]            crow_q;
  logic                       last_q;

  assign en_out      = !out_valid_q || !out_stall_i;
  assign en4         = !s4_valid_q || en_out;
  assign en3         = !s3_valid_q || en4;
  assign en2         = !s2_valid_q || en3;
  assign win_ready_o = en2;

  // stage 2: weighted sums and magnitudes
  always_comb begin
    logic signed [ValW-1:0] pe [9];
    logic signed [ValW-1:0] sum;
    logic signed [ValW-1:0] gsum;
    for (int i = 0; i < 9; i++) begin
      pe[i] = $signed({{(ValW-PixW){1'b0}}, win_i[i]});
    end
    sum  = pe[0] + pe[1] + pe[2] + pe[3] + pe[4] + pe[5] + pe[6] + pe[7] + pe[8];
    gsum = pe[0] + (pe[1] <<< 1) + pe[2] + (pe[3] <<< 1) + (pe[4] <<< 2)
         + (pe[5] <<< 1) + pe[6] + (pe[7] <<< 1) + pe[8];
    unique case (meta_i.mode)
      ModeBox:      s2_val_d = sum;
      ModeGauss:    s2_val_d = gsum;
      ModePrewittX: s2_val_d = abs_val((pe[2] + pe[5] + pe[8]) - (pe[0] + pe[3] + pe[6]));
      ModePrewittY: s2_val_d = abs_val((pe[6] + pe[7] + pe[8]) - (pe[0] + pe[1] + pe[2]));
      ModeSobelX:   s2_val_d = abs_val((pe[2] + (pe[5] <<< 1) + pe[8])
                                     - (pe[0] + (pe[3] <<< 1) + pe[6]));
      ModeSobelY:   s2_val_d = abs_val((pe[6] + (pe[7] <<< 1) + pe[8])
                                     - (pe[0] + (pe[1] <<< 1) + pe[2]));
      ModeLaplace:  s2_val_d = abs_val(pe[4] * 14'sd9 - sum);
      ModeSharpen:  s2_val_d = pe[4] * 14'sd10 - sum;
      default:      s2_val_d = sum;
    endcase
  end

  // stage 3: scaling, box reciprocal estimate
  always_comb begin
    logic [BoxSumW-1:0]   vu;
    logic [Div3ProdW-1:0] prod3;
    vu       = s2_val_q[BoxSumW-1:0];
    prod3    = Div3ProdW'(vu) * Div3ProdW'(Div3Recip);
    s3_quo_d = BoxRecipW'(vu) * BoxRecipW'(BoxRecip);
    s3_num_d = BoxProdW'(vu) * BoxProdW'(BoxNum);
    unique case (s2_meta_q.mode)
      ModeBox:      s3_res_d = '0;
      ModeGauss:    s3_res_d = vu[4 +: PixW];
      ModePrewittX: s3_res_d = prod3[Div3Shift +: PixW];
      ModePrewittY: s3_res_d = prod3[Div3Shift +: PixW];
      ModeSobelX:   s3_res_d = vu[2 +: PixW];
      ModeSobelY:   s3_res_d = vu[2 +: PixW];
      ModeLaplace:  s3_res_d = vu[3 +: PixW];
      ModeSharpen: begin
        if (s2_val_q < 0) begin
          s3_res_d = '0;
        end else if (s2_val_q > 14'sd255) begin
          s3_res_d = '1;
        end else begin
          s3_res_d = s2_val_q[PixW-1:0];
        end
      end
      default:      s3_res_d = '0;
    endcase
  end

  // output: box estimate corrected by one remainder compare
  always_comb begin
    logic [BoxProdW-1:0] rem;
    rem = s4_num_q - s4_mq_q;
    if (s4_meta_q.mode == ModeBox) begin
      filtered_d = s4_q0_q + PixW'(rem >= BoxProdW'(BoxDen));
    end else begin
      filtered_d = s4_res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en2) begin
        s2_valid_q <= win_valid_i;
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q;
      end
      if (en4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (en_out) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && win_valid_i) begin
      s2_val_q  <= s2_val_d;
      s2_meta_q <= meta_i;
    end
    if (en3 && s2_valid_q) begin
      s3_res_q  <= s3_res_d;
      s3_quo_q  <= s3_quo_d;
      s3_num_q  <= s3_num_d;
      s3_meta_q <= s2_meta_q;
    end
    if (en4 && s3_valid_q) begin
      s4_res_q  <= s3_res_q;
      s4_q0_q   <= s3_quo_q[BoxShift +: PixW];
      s4_num_q  <= s3_num_q;
      s4_mq_q   <= BoxProdW'(s3_quo_q[BoxShift +: PixW]) * BoxProdW'(BoxDen);
      s4_meta_q <= s3_meta_q;
    end
    if (en_out && s4_valid_q) begin
      filtered_q <= filtered_d;
      ccol_q     <= s4_meta_q.col - 1'b1;
      crow_q     <= s4_meta_q.row - 1'b1;
      last_q     <= s4_meta_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filtered_q;
  assign centre_col_o = ccol_q;
  assign centre_row_o = crow_q;
  assign frame_last_o = last_q;

endmodule

FILE: hw/rtl/window3x3_convolution_filter.sv
// top level of the line-buffered 3x3 window convolution filter
// Usage:
// Grey pixels enter in raster order on in_valid_i / pixel_i; a transaction
// completes at a rising edge with in_valid_i high and in_stall_o low.
// For every pixel whose 3x3 neighbourhood lies inside the frame, one result
// leaves on out_valid_o with filtered_o, the centre position and frame_last_o,
// taken at an edge with out_stall_i low. Border pixels give no result.
// Throughput is one pixel per clock while in_stall_o is low, set by the single
// read and write port of both line memories, each read once per pixel.
// Frame size and mode sit in APB registers at 0x0, 0x4 and 0x8; writing width
// or height restarts the frame at column and row zero. Mode changes apply from
// the next pixel. The user must write registers only while the filter is idle;
// the block does not enforce this. Reset clears counters, window and pipeline;
// the line memories are not cleared, and no clearing pass is needed, so pixels
// are taken right away. When the receiver stalls, the result register holds
// and the pipeline keeps filling its empty stages before in_stall_o goes high.
module window3x3_convolution_filter import wcf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     pixel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     filtered_o,
  output logic [ColW-1:0]     centre_col_o,
  output logic [RowW-1:0]     centre_row_o,
  output logic                frame_last_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [CfgW-1:0] width_q;
  logic [CfgW-1:0] height_q;
  mode_e           mode_q;
  logic            cfg_wr;
  logic [1:0]      reg_idx;
  frame_cfg_t      frame_cfg;
  logic            win_valid;
  logic            kern_ready;
  win_t            win;
  pix_meta_t       win_meta;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(MaxWidth);
      height_q <= CfgW'(MaxHeight);
      mode_q   <= ModeBox;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegWidthIdx:  width_q  <= pwdata[CfgW-1:0];
        RegHeightIdx: height_q <= pwdata[CfgW-1:0];
        RegModeIdx:   mode_q   <= mode_e'(pwdata[ModeW-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegWidthIdx:  prdata = ApbDataW'(width_q);
      RegHeightIdx: prdata = ApbDataW'(height_q);
      RegModeIdx:   prdata = ApbDataW'(mode_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    frame_cfg.wm1     = width_m1(width_q);
    frame_cfg.hm1     = height_m1(height_q);
    frame_cfg.restart = cfg_wr && ((reg_idx == RegWidthIdx) || (reg_idx == RegHeightIdx));
    frame_cfg.mode    = mode_q;
  end

  wcf_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (frame_cfg),
    .in_valid_i  (in_valid_i),
    .pixel_i     (pixel_i),
    .in_stall_o  (in_stall_o),
    .win_ready_i (kern_ready),
    .win_valid_o (win_valid),
    .win_o       (win),
    .meta_o      (win_meta)
  );

  wcf_kernel u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_valid_i  (win_valid),
    .win_i        (win),
    .meta_i       (win_meta),
    .win_ready_o  (kern_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .filtered_o   (filtered_o),
    .centre_col_o (centre_col_o),
    .centre_row_o (centre_row_o),
    .frame_last_o (frame_last_o)
  );

`ifndef SYNTH
  a_win_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid && !kern_ready |=> win_valid && $stable(win) && $stable(win_meta))
    else $error("window transaction changed while kernel was full");

  a_kern_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !kern_ready |-> out_valid_o && out_stall_i)
    else $error("kernel pipeline blocked without a stalled result");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> win_valid && !kern_ready)
    else $error("input stalled while window stage could advance");
`endif

endmodule
